[src/mexp_pkg.sv]
package mexp_pkg;

    localparam int DATA_W    = 32;
    localparam int POWER_W   = DATA_W - 1;
    localparam int EXP_BITS  = 32;
    localparam int MUL_STEPS = 31;
    localparam int CNT_MAX   = (DATA_W > MUL_STEPS) ? DATA_W : MUL_STEPS;
    localparam int CNT_W     = $clog2(CNT_MAX);

    localparam logic [DATA_W-1:0] MODULUS_RESET = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] MODULUS_MAX   = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic load;
        logic red_step;
        logic mul_init;
        logic mul_step;
        logic exp_shift;
        logic out_load;
    } mexp_cmd_t;

    typedef struct packed {
        logic exp_zero;
    } mexp_sts_t;

endpackage

[src/mexp_dp.sv]
module mexp_dp import mexp_pkg::*; (
    input  logic                aclk,
    input  logic                cfg_we,
    input  logic [DATA_W-1:0]   cfg_modulus,
    input  logic [DATA_W-1:0]   s_base,
    input  logic [EXP_BITS-1:0] s_exponent,
    input  mexp_cmd_t           cmd,
    output mexp_sts_t           sts,
    output logic [POWER_W-1:0]  m_power,
    input  logic                aresetn
);

    // a + b reduced once; both operands are below m
    function automatic logic [DATA_W-1:0] mod_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b,
                                                  input logic [DATA_W-1:0] m);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[DATA_W-1:0];
    endfunction

    logic [DATA_W-1:0]   mod_reg,  mod_next;
    logic [DATA_W-1:0]   base_reg, base_next;
    logic [EXP_BITS-1:0] exp_reg,  exp_next;
    logic [DATA_W-1:0]   sq_reg,   sq_next;
    logic [DATA_W-1:0]   res_reg,  res_next;
    logic [DATA_W-1:0]   accr_reg, accr_next;
    logic [DATA_W-1:0]   accs_reg, accs_next;
    logic [DATA_W-1:0]   y_reg,    y_next;
    logic [DATA_W-1:0]   xr_reg,   xr_next;
    logic [DATA_W-1:0]   xs_reg,   xs_next;
    logic [POWER_W-1:0]  pow_reg,  pow_next;
    logic [DATA_W:0]     rem_try;

    always_comb begin
        mod_next = mod_reg;
        if (cfg_we) begin
            if (cfg_modulus == '0) begin
                mod_next = DATA_W'(1);
            end else if (cfg_modulus > MODULUS_MAX) begin
                mod_next = MODULUS_MAX;
            end else begin
                mod_next = cfg_modulus;
            end
        end
    end

    assign rem_try = {sq_reg, base_reg[DATA_W-1]};

    always_comb begin
        base_next = base_reg;
        exp_next  = exp_reg;
        sq_next   = sq_reg;
        res_next  = res_reg;
        accr_next = accr_reg;
        accs_next = accs_reg;
        y_next    = y_reg;
        xr_next   = xr_reg;
        xs_next   = xs_reg;
        pow_next  = pow_reg;
        if (cmd.load) begin
            base_next = s_base;
            exp_next  = s_exponent;
            sq_next   = '0;
            res_next  = (mod_reg == DATA_W'(1)) ? '0 : DATA_W'(1);
        end
        if (cmd.red_step) begin
            base_next = {base_reg[DATA_W-2:0], 1'b0};
            if (rem_try >= {1'b0, mod_reg}) begin
                sq_next = DATA_W'(rem_try - {1'b0, mod_reg});
            end else begin
                sq_next = rem_try[DATA_W-1:0];
            end
        end
        if (cmd.mul_init) begin
            accr_next = '0;
            accs_next = '0;
            y_next    = sq_reg;
            xr_next   = res_reg;
            xs_next   = sq_reg;
        end
        if (cmd.mul_step) begin
            if (xr_reg[0]) begin
                accr_next = mod_add(accr_reg, y_reg, mod_reg);
            end
            if (xs_reg[0]) begin
                accs_next = mod_add(accs_reg, y_reg, mod_reg);
            end
            y_next  = mod_add(y_reg, y_reg, mod_reg);
            xr_next = xr_reg >> 1;
            xs_next = xs_reg >> 1;
        end
        if (cmd.exp_shift) begin
            if (exp_reg[0]) begin
                res_next = accr_reg;
            end
            sq_next  = accs_reg;
            exp_next = exp_reg >> 1;
        end
        if (cmd.out_load) begin
            pow_next = res_reg[POWER_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= MODULUS_RESET;
        end else begin
            mod_reg <= mod_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
        accr_reg <= accr_next;
        accs_reg <= accs_next;
        y_reg    <= y_next;
        xr_reg   <= xr_next;
        xs_reg   <= xs_next;
        pow_reg  <= pow_next;
    end

    assign sts.exp_zero = (exp_reg == '0);
    assign m_power      = pow_reg;

endmodule

[src/mexp_ctrl.sv]
module mexp_ctrl import mexp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  mexp_sts_t sts,
    output mexp_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             mv_reg,    mv_next;
    logic             out_free;

    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = mv_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(DATA_W - 1);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                cmd.red_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_CHECK;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_CHECK: begin
                if (sts.exp_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.mul_init = 1'b1;
                    cnt_next     = CNT_W'(MUL_STEPS - 1);
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_UPDATE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_UPDATE: begin
                cmd.exp_shift = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_REDUCE && cnt_reg == CNT_W'(DATA_W - 1)))
        else $error("accepted request did not start reduction");

    a_mul_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && cnt_reg == '0) |=> (state_reg == ST_UPDATE))
        else $error("product did not end after its last step");

    a_finish_exp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> sts.exp_zero)
        else $error("finished with exponent bits left");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |-> !cmd.out_load)
        else $error("pending result overwritten");
`endif

endmodule

[src/modular_exponentiation_unit.sv]
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// input    | s_valid, s_ready, s_base, s_exponent    | in
// result   | m_valid, m_ready, m_power               | out
// config   | cfg_valid, cfg_ready, cfg_modulus       | in
//
// One request at a time: a new one is accepted only after the last result has been
// loaded into the output register. The work is the 32-step base reduction and, for each
// of the k exponent bits (k = highest set bit position plus one, up to 32), a check,
// the 31-step shift-add product loop and an update; square and multiply together.
// Reset (synchronous, aresetn low) sets the modulus to 2^31-1 and idles.
// A finished result waits in the output register while m_ready is low.
module modular_exponentiation_unit import mexp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DATA_W-1:0]   cfg_modulus,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [DATA_W-1:0]   s_base,
    input  logic [EXP_BITS-1:0] s_exponent,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [POWER_W-1:0]  m_power
);

    mexp_cmd_t cmd;
    mexp_sts_t sts;

    assign cfg_ready = 1'b1;

    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mexp_dp u_dp (
        .aclk        (aclk),
        .cfg_we      (cfg_valid),
        .cfg_modulus (cfg_modulus),
        .s_base      (s_base),
        .s_exponent  (s_exponent),
        .cmd         (cmd),
        .sts         (sts),
        .m_power     (m_power),
        .aresetn     (aresetn)
    );

endmodule

[sim/modular_exponentiation_unit_tb.sv]
`timescale 1ns / 100ps

module modular_exponentiation_unit_tb;
    import mexp_pkg::*;

    typedef struct {
        logic [DATA_W-1:0]   base;
        logic [EXP_BITS-1:0] exponent;
        logic [POWER_W-1:0]  power;
    } power_req_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [DATA_W-1:0]   cfg_modulus;
    logic                s_valid;
    logic                s_ready;
    logic [DATA_W-1:0]   s_base;
    logic [EXP_BITS-1:0] s_exponent;
    logic                m_valid;
    logic                m_ready;
    logic [POWER_W-1:0]  m_power;

    power_req_t        pending_powers[$];
    power_req_t        seen_req;
    logic [DATA_W-1:0] modulus_shadow = MODULUS_RESET;
    int                send_idle_pct = 7;
    int                recv_idle_pct = 61;
    int                failures = 0;
    int                requests_sent = 0;
    int                results_checked = 0;
    int                modulus_writes = 0;

    modular_exponentiation_unit uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_modulus(cfg_modulus),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_base     (s_base),
        .s_exponent (s_exponent),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_power    (m_power)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("modular_exponentiation_unit verification failed");
        $finish;
    end

    // (x * y) mod m, shift-and-add over MUL_STEPS bits of x
    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd0;
        x = x % m;
        y = y % m;
        for (int i = 0; i < MUL_STEPS; i++) begin
            if (x[i]) acc = (acc + y) % m;
            y = (y * 2) % m;
        end
        return acc;
    endfunction

    function automatic logic [POWER_W-1:0] predict_power(logic [DATA_W-1:0] base,
                                                         logic [EXP_BITS-1:0] expo,
                                                         logic [DATA_W-1:0] modulus);
        logic [63:0] m;
        logic [63:0] e;
        logic [63:0] acc;
        logic [63:0] sq;
        if (modulus == '0) m = 64'd1;
        else if (modulus > MODULUS_MAX) m = 64'(MODULUS_MAX);
        else m = 64'(modulus);
        e   = 64'(expo);
        acc = 64'd1 % m;
        sq  = 64'(base) % m;
        while (e != 64'd0) begin
            if (e[0]) acc = mul_mod(acc, sq, m);
            sq = mul_mod(sq, sq, m);
            e  = e >> 1;
        end
        acc = acc % m;
        return acc[POWER_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pick_modulus();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 32'd1 : 32'd0;
            1: return MODULUS_MAX;
            2: return MODULUS_RESET;
            3: return $urandom_range(1000, 2);
            4: return $urandom();
            5: return MODULUS_MAX - $urandom_range(1000, 0);
            default: return $urandom_range(32'h8000_0000, 1);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_base();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [EXP_BITS-1:0] pick_exponent();
        case ($urandom_range(9))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3, 4, 5: return $urandom() >> $urandom_range(31, 1);
            default: return $urandom();
        endcase
    endfunction

    // valid is left high after a request so back-to-back requests need no toggle
    task automatic send_request(input logic [DATA_W-1:0] base, input logic [EXP_BITS-1:0] expo);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid    <= 1'b1;
        s_base     <= base;
        s_exponent <= expo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_powers.push_back('{base: base, exponent: expo,
                                   power: predict_power(base, expo, modulus_shadow)});
        requests_sent++;
    endtask

    task automatic write_modulus(input logic [DATA_W-1:0] value);
        cfg_valid   <= 1'b1;
        cfg_modulus <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid      <= 1'b0;
        modulus_shadow = value;
        modulus_writes++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_powers.size() == 0) begin
                $display("%0t: unexpected result, actual power %h", $realtime, m_power);
                failures++;
            end else begin
                seen_req = pending_powers.pop_front();
                results_checked++;
                if (m_power !== seen_req.power) begin
                    $display("%0t: power mismatch base %h exp %h: expected %h actual %h",
                             $realtime, seen_req.base, seen_req.exponent,
                             seen_req.power, m_power);
                    failures++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // reset modulus 2^31-1
    task automatic test_directed_powers();
        send_request('0, '0);
        send_request('0, 32'd5);
        send_request('1, '1);
        send_request(32'h7FFF_FFFF, 32'd3);
        send_request(32'd2, 32'd30);
        send_request(32'd2, 32'd31);
        send_request(32'h8000_0000, 32'h8000_0000);
        send_request(32'd12345, 32'd1);
        drain_results();
    endtask

    // unit modulus, zero (acts as 1), 2^31, above 2^31 (saturates), 2
    task automatic test_modulus_extremes();
        logic [DATA_W-1:0] settings[5];
        settings = '{32'd1, 32'd0, MODULUS_MAX, 32'hFFFF_FFFF, 32'd2};
        foreach (settings[i]) begin
            write_modulus(settings[i]);
            send_request('1, '0);
            send_request('1, '1);
            send_request(32'h7FFF_FFFF, 32'd2);
            drain_results();
        end
    endtask

    task automatic test_random_powers(input int count, input int send_pct, input int recv_pct);
        int left;
        int chunk;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        left = count;
        while (left > 0) begin
            chunk = $urandom_range(40, 20);
            if (chunk > left) chunk = left;
            write_modulus(pick_modulus());
            repeat (chunk) send_request(pick_base(), pick_exponent());
            drain_results();
            left -= chunk;
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_modulus = '0;
        s_valid     = 1'b0;
        s_base      = '0;
        s_exponent  = '0;
        m_ready     = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_powers();
        test_modulus_extremes();
        test_random_powers(186, 7, 61);
        test_random_powers(186, 61, 7);
        test_random_powers(186, 0, 0);

        $display("Sent %0d power requests across %0d modulus writes; %0d results checked.",
                 requests_sent, modulus_writes, results_checked);
        $display("Covered zero/unit/saturated modulus, zero and full exponents, both stall mixes.");
        if (failures == 0) begin
            $display("modular_exponentiation_unit verification clean");
        end else begin
            $display("modular_exponentiation_unit verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
src/mexp_pkg.sv
src/mexp_dp.sv
src/mexp_ctrl.sv
src/modular_exponentiation_unit.sv
sim/modular_exponentiation_unit_tb.sv
